### hdl/ipc_pkg.sv
// Shared types and constants of the isolated pixel check unit.
// No dependencies; used by ipc_cell, ipc_result and isolated_pixel_check_unit.
package ipc_pkg;

    // Width and reset value of the frame size registers
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Controls shared by every column cell
    typedef struct packed {
        logic adv;        // pixel transfer this cycle
        logic pixel;      // pixel value of the transfer
        logic row_end;    // transfer ends a row
        logic frame_end;  // transfer ends the frame
    } ipc_ctrl_t;

endpackage

### hdl/ipc_cell.sv
// One column cell of the isolated pixel check: row-above bit, current-row bit
// and pending bit. Depends on ipc_pkg; chained by isolated_pixel_check_unit.
module ipc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ipc_pkg::ipc_ctrl_t ctrl,
    input  logic              sel,        // this column takes the pixel
    input  logic              in_row,     // column lies inside the frame width
    input  logic              left_cur,   // current-row bit of the left cell
    input  logic              right_clr,  // right cell found this pixel as neighbour
    output logic              cur,        // current-row bit, to the right cell
    output logic              clr_left,   // clear the left cell's pending bit
    output logic              pend,       // pending bit as held
    output logic              pend_final  // pending bit after this transfer
);
    import ipc_pkg::*;

    logic prev_reg, prev_next;
    logic cur_reg, cur_next;
    logic pend_reg, pend_next;
    logic cur_upd, pend_upd;

    assign cur      = cur_reg;
    assign pend     = pend_reg;
    assign clr_left = sel && ctrl.pixel && left_cur;

    // Apply the pixel and the neighbour clear
    always_comb
    begin
        cur_upd  = cur_reg;
        pend_upd = pend_reg;
        if (sel)
        begin
            cur_upd  = ctrl.pixel;
            pend_upd = ctrl.pixel && !prev_reg && !left_cur;
        end
        if (right_clr)
        begin
            pend_upd = 1'b0;
        end
    end

    assign pend_final = pend_upd;

    // Roll the row over at row end, clear everything at frame end
    always_comb
    begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        pend_next = pend_reg;
        if (ctrl.adv)
        begin
            cur_next  = cur_upd;
            pend_next = pend_upd;
            if (ctrl.frame_end)
            begin
                prev_next = 1'b0;
                cur_next  = 1'b0;
                pend_next = 1'b0;
            end
            else if (ctrl.row_end)
            begin
                prev_next = in_row ? cur_upd : 1'b0;
                cur_next  = 1'b0;
                if (!in_row)
                begin
                    pend_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            cur_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            cur_reg  <= cur_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### hdl/ipc_result.sv
// Frame result stage: captures the pending bits at frame end, reduces them
// and holds the result for the receiver. Depends on ipc_pkg.
module ipc_result #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,       // frame-end pixel transfer
    input  logic                 flag,       // no isolated pixel above the last row
    input  logic [MAX_WIDTH-1:0] pend,       // last-row pending bits, masked to width
    output logic                 full,       // both stages held and receiver stalls
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 all_have_neighbor
);
    import ipc_pkg::*;

    logic                 snap_valid_reg, snap_valid_next;
    logic                 snap_flag_reg;
    logic [MAX_WIDTH-1:0] snap_pend_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_data_reg;
    logic                 advance;

    assign advance = snap_valid_reg && (!out_valid_reg || !result_stall);
    assign full    = snap_valid_reg && out_valid_reg && result_stall;

    // Snapshot and output valid control
    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (load)
        begin
            snap_valid_next = 1'b1;
        end
        else if (advance)
        begin
            snap_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the captured frame state and the reduced result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_flag_reg <= flag;
            snap_pend_reg <= pend;
        end
        if (advance)
        begin
            out_data_reg <= snap_flag_reg && !(|snap_pend_reg);
        end
    end

    assign result_valid      = out_valid_reg;
    assign all_have_neighbor = out_data_reg;

endmodule

### hdl/isolated_pixel_check_unit.sv
// Isolated pixel check over a binary image: top level with the column cell chain,
// counters and configuration. Depends on ipc_pkg, ipc_cell and ipc_result.
//
// Usage:
//   Pixels arrive in raster order on pixel / pixel_valid / pixel_stall; a
//   transfer happens when pixel_valid is high and pixel_stall is low. One
//   pixel can be taken every clock. The frame size sits in two registers
//   written over cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
//   always high. Sizes of zero act as one, sizes above the maximum saturate.
//   After the last pixel of a frame one result appears on all_have_neighbor
//   with result_valid: the transfer captures the pending bits, and the
//   output register takes their reduction once it is free. The next frame
//   streams in meanwhile at one pixel per clock while pixel_stall is low.
//   A result waits while result_stall is high; pixel_stall rises only when a
//   second result is captured behind a held one.
//   Reset (rst_n low, asynchronous) clears the cells and counters, sets the
//   flag and sets both size registers to 64.
module isolated_pixel_check_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic                         pixel,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         all_have_neighbor,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  ipc_pkg::cfg_index_t          cfg_index,
    input  logic [ipc_pkg::CFG_W-1:0]    cfg_data
);
    import ipc_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [CB-1:0]    col_cnt_reg, col_cnt_next;
    logic [RB-1:0]    row_cnt_reg, row_cnt_next;
    logic             flag_reg, flag_next;

    logic [CB-1:0]    last_col, col;
    logic [RB-1:0]    last_row, row;
    logic             adv, row_end, frame_end, kill, full;
    ipc_ctrl_t        ctrl;

    logic [MAX_WIDTH-1:0] cur_vec, clr_vec, pend_vec, pend_fin_vec;
    logic [MAX_WIDTH-1:0] sel_vec, in_row_vec;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective last column and row, sizes clamped to one and to the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            last_col = CB'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CB'(width_reg - 1'b1);
        end
        if (height_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            last_row = RB'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = RB'(height_reg - 1'b1);
        end
    end

    // Saturate the position to the frame after a size change
    assign col       = (col_cnt_reg > last_col) ? last_col : col_cnt_reg;
    assign row       = (row_cnt_reg > last_row) ? last_row : row_cnt_reg;
    assign row_end   = (col == last_col);
    assign frame_end = row_end && (row == last_row);

    assign pixel_stall = full;
    assign adv         = pixel_valid && !pixel_stall;

    assign ctrl.adv       = adv;
    assign ctrl.pixel     = pixel;
    assign ctrl.row_end   = row_end;
    assign ctrl.frame_end = frame_end;

    // Pixel above left pending and this pixel clear: the one above is isolated
    assign kill = pend_vec[col] && !pixel;

    // Advance counters and flag
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        flag_next    = flag_reg;
        if (adv)
        begin
            if (frame_end)
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
                flag_next    = 1'b1;
            end
            else
            begin
                flag_next = flag_reg && !kill;
                if (row_end)
                begin
                    col_cnt_next = '0;
                    row_cnt_next = row + 1'b1;
                end
                else
                begin
                    col_cnt_next = col + 1'b1;
                    row_cnt_next = row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= CFG_SIZE_RESET;
            height_reg  <= CFG_SIZE_RESET;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            flag_reg    <= 1'b1;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            flag_reg    <= flag_next;
        end
    end

    // Chain of column cells
    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_cell
        logic left_cur, right_clr;

        assign sel_vec[i]    = (col == CB'(i));
        assign in_row_vec[i] = (CB'(i) <= last_col);

        if (i == 0)
        begin : g_first
            assign left_cur = 1'b0;
        end
        else
        begin : g_inner
            assign left_cur = cur_vec[i-1];
        end

        if (i == MAX_WIDTH - 1)
        begin : g_last
            assign right_clr = 1'b0;
        end
        else
        begin : g_body
            assign right_clr = clr_vec[i+1];
        end

        ipc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sel        (sel_vec[i]),
            .in_row     (in_row_vec[i]),
            .left_cur   (left_cur),
            .right_clr  (right_clr),
            .cur        (cur_vec[i]),
            .clr_left   (clr_vec[i]),
            .pend       (pend_vec[i]),
            .pend_final (pend_fin_vec[i])
        );
    end

    // Frame result capture and output
    ipc_result #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_result (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (adv && frame_end),
        .flag              (flag_reg && !kill),
        .pend              (pend_fin_vec & in_row_vec),
        .full              (full),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .all_have_neighbor (all_have_neighbor)
    );

endmodule
